[sv/gbn_pkg.sv]
// gbn_pkg: shared widths, box record type and register codes for the
// greedy box suppression unit and its port checker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gbn_pkg;

   // box geometry and ranking widths
   localparam int COORD_BITS = 12;
   localparam int SIZE_BITS  = COORD_BITS + 1;
   localparam int SCORE_BITS = 10;
   localparam int BOX_BITS   = 2 * COORD_BITS + 2 * SIZE_BITS + SCORE_BITS;
   localparam int TDATA_BITS = ((BOX_BITS + 7) / 8) * 8;
   localparam int PAD_BITS   = TDATA_BITS - BOX_BITS;

   // store depths and counter widths
   localparam int MAX_CANDIDATES = 64;
   localparam int CAND_AW        = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
   localparam int CAND_CW        = $clog2(MAX_CANDIDATES + 1);
   localparam int MAX_KEPT       = 8;
   localparam int RESULT_CAP     = 8;
   localparam int KEEP_CAP       = (MAX_KEPT < RESULT_CAP) ? MAX_KEPT : RESULT_CAP;
   localparam int KEPT_AW        = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int KEPT_CW        = $clog2(MAX_KEPT + 1);

   // overlap arithmetic widths
   localparam int EDGE_BITS = SIZE_BITS + 1;
   localparam int AREA_BITS = 2 * SIZE_BITS;
   localparam int UNI_BITS  = AREA_BITS + 1;
   localparam int THR_BITS  = 9;
   localparam int PROD_BITS = THR_BITS + UNI_BITS;
   localparam int FRAC_BITS = 8;
   localparam int STAGES    = 5;

   // control registers
   localparam int LIMIT_BITS    = 4;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = THR_BITS;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OVERLAP_THRESHOLD = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BOX_LIMIT         = 1'd1;
   localparam logic [THR_BITS-1:0]     THRESHOLD_RESET       = 9'd77;
   localparam logic [LIMIT_BITS-1:0]   LIMIT_RESET           = 4'd3;

   // one box, left edge in the lowest bits
   typedef struct packed {
      logic [SCORE_BITS-1:0] score;
      logic [SIZE_BITS-1:0]  box_height;
      logic [SIZE_BITS-1:0]  box_width;
      logic [COORD_BITS-1:0] top;
      logic [COORD_BITS-1:0] left;
   } box_type;

endpackage

`default_nettype wire

[sv/greedy_box_nms_unit.sv]
// greedy_box_nms_unit: score-ordered candidate memory, greedy overlap
// suppression and kept-box output; depends on gbn_pkg
`timescale 1ns / 1ps
`default_nettype none

// Boxes of one set arrive one per transaction (tuser marks a box, tlast ends
// the set) and go into a 64-entry candidate memory kept sorted by falling
// score, equal scores in arrival order. An item that carries no box, finds
// the memory empty or finds it full moves nothing; otherwise every stored box
// of lower score moves down a slot, one at a time through the single read and
// write port of the candidate memory. At the end of a set each candidate is
// checked against the kept boxes through a five-stage overlap pipeline fed
// from the kept-box memory, one kept box a cycle; after the pipeline drains
// it is kept if no kept box overlaps it, and while nothing is kept yet it is
// kept with no check. The walk stops once the box limit is reached. Kept boxes
// then leave in order, each waiting for a free output register, the last
// with tlast; an empty set gives one result with tuser low. The input side is
// ready again as soon as the last result sits in the output register. No
// clearing pass is needed after reset.
module greedy_box_nms_unit (
   input  wire                                 clock,
   input  wire                                 reset,
   // input transactions
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [gbn_pkg::TDATA_BITS-1:0]      req_tdata,  // left, top, box_width,
                                                           // box_height, score
   input  wire                                 req_tuser,  // has_box
   input  wire                                 req_tlast,  // end_of_set
   // result transactions
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [gbn_pkg::TDATA_BITS-1:0]      rsp_tdata,  // out_left, out_top, out_width,
                                                           // out_height, out_score
   output logic                                rsp_tuser,  // found
   output logic                                rsp_tlast,  // last_result
   // control register writes
   input  wire                                 csr_we,
   input  wire  [gbn_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire  [gbn_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int CAND_AW   = gbn_pkg::CAND_AW;
   localparam int CAND_CW   = gbn_pkg::CAND_CW;
   localparam int KEPT_AW   = gbn_pkg::KEPT_AW;
   localparam int KEPT_CW   = gbn_pkg::KEPT_CW;
   localparam int EDGE_BITS = gbn_pkg::EDGE_BITS;
   localparam int SIZE_BITS = gbn_pkg::SIZE_BITS;
   localparam int AREA_BITS = gbn_pkg::AREA_BITS;
   localparam int UNI_BITS  = gbn_pkg::UNI_BITS;
   localparam int PROD_BITS = gbn_pkg::PROD_BITS;
   localparam int FRAC_BITS = gbn_pkg::FRAC_BITS;
   localparam int STAGES    = gbn_pkg::STAGES;

   // sequencer states
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_INS_CMP = 4'd1;
   localparam logic [3:0] S_INS_PUT = 4'd2;
   localparam logic [3:0] S_SETUP   = 4'd3;
   localparam logic [3:0] S_WALK_RD = 4'd4;
   localparam logic [3:0] S_WALK_LD = 4'd5;
   localparam logic [3:0] S_CMP     = 4'd6;
   localparam logic [3:0] S_DRAIN   = 4'd7;
   localparam logic [3:0] S_KEEP    = 4'd8;
   localparam logic [3:0] S_NEXT    = 4'd9;
   localparam logic [3:0] S_EMIT_RD = 4'd10;
   localparam logic [3:0] S_EMIT_LD = 4'd11;
   localparam logic [3:0] S_EMPTY   = 4'd12;

   // control registers
   logic [gbn_pkg::THR_BITS-1:0]   thr_ff;
   logic [gbn_pkg::LIMIT_BITS-1:0] box_limit_ff;
   logic [KEPT_CW-1:0]             limit;

   // sequencer state
   logic [3:0]         state_ff, state_in;
   logic [CAND_CW-1:0] cand_cnt_ff, cand_cnt_in;
   logic [CAND_AW-1:0] pos_ff, pos_in;
   logic [CAND_CW-1:0] walk_ff, walk_in;
   logic [KEPT_CW-1:0] kept_cnt_ff, kept_cnt_in;
   logic [KEPT_AW-1:0] k_ff, k_in;
   logic [KEPT_AW-1:0] emit_ff, emit_in;
   logic               drop_ff, drop_in;
   logic [STAGES-1:0]  vld_ff, vld_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // item being loaded and candidate under test
   gbn_pkg::box_type nb_ff;
   logic             end_ff;
   gbn_pkg::box_type cand_ff;
   gbn_pkg::box_type req_box;

   // candidate memory
   gbn_pkg::box_type   cand_mem [gbn_pkg::MAX_CANDIDATES];
   gbn_pkg::box_type   cand_rd_ff;
   logic               cand_we;
   logic [CAND_AW-1:0] cand_wa, cand_ra;
   gbn_pkg::box_type   cand_wd;

   // kept-box memory
   gbn_pkg::box_type   kept_mem [gbn_pkg::MAX_KEPT];
   gbn_pkg::box_type   kept_rd_ff;
   logic               kept_we;
   logic [KEPT_AW-1:0] kept_wa, kept_ra;

   // output register
   gbn_pkg::box_type rsp_box_ff;
   logic             rsp_found_ff, rsp_last_ff;
   logic             rsp_load, rsp_load_found, rsp_load_last;
   logic             slot_free;

   // overlap pipeline
   logic [gbn_pkg::COORD_BITS-1:0] x1, y1;
   logic [EDGE_BITS-1:0]           a_x2, b_x2, x2, a_y2, b_y2, y2;
   logic [SIZE_BITS-1:0]           iw, ih;
   logic [SIZE_BITS-1:0]           iw_ff, ih_ff;
   logic [AREA_BITS-1:0]           area_a_ff, area_b_ff;
   logic [AREA_BITS-1:0]           inter2_ff, inter3_ff, inter4_ff;
   logic [UNI_BITS-1:0]            sum_ff, uni_ff;
   logic [PROD_BITS-1:0]           prod_ff;
   logic                           uni_zero_ff;
   logic                           hit;

   logic accept;

   assign req_box = gbn_pkg::box_type'(req_tdata[gbn_pkg::BOX_BITS-1:0]);
   assign accept  = req_tvalid && req_tready;

   // control register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= gbn_pkg::THRESHOLD_RESET;
         box_limit_ff <= gbn_pkg::LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            gbn_pkg::CSR_OVERLAP_THRESHOLD: thr_ff <= csr_wdata;
            gbn_pkg::CSR_BOX_LIMIT: box_limit_ff <= csr_wdata[gbn_pkg::LIMIT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // effective box limit: zero means one, clamp to the kept capacity
   always_comb begin
      priority if (box_limit_ff == '0) begin
         limit = KEPT_CW'(1);
      end else if (int'(box_limit_ff) > gbn_pkg::KEEP_CAP) begin
         limit = KEPT_CW'(gbn_pkg::KEEP_CAP);
      end else begin
         limit = KEPT_CW'(box_limit_ff);
      end
   end

   // overlap stage one: intersection extent
   always_comb begin
      x1   = (cand_ff.left > kept_rd_ff.left) ? cand_ff.left : kept_rd_ff.left;
      y1   = (cand_ff.top > kept_rd_ff.top) ? cand_ff.top : kept_rd_ff.top;
      a_x2 = EDGE_BITS'(cand_ff.left) + EDGE_BITS'(cand_ff.box_width);
      b_x2 = EDGE_BITS'(kept_rd_ff.left) + EDGE_BITS'(kept_rd_ff.box_width);
      a_y2 = EDGE_BITS'(cand_ff.top) + EDGE_BITS'(cand_ff.box_height);
      b_y2 = EDGE_BITS'(kept_rd_ff.top) + EDGE_BITS'(kept_rd_ff.box_height);
      x2   = (a_x2 < b_x2) ? a_x2 : b_x2;
      y2   = (a_y2 < b_y2) ? a_y2 : b_y2;
      iw   = (x2 > EDGE_BITS'(x1)) ? SIZE_BITS'(x2 - EDGE_BITS'(x1)) : '0;
      ih   = (y2 > EDGE_BITS'(y1)) ? SIZE_BITS'(y2 - EDGE_BITS'(y1)) : '0;
   end

   // overlap pipeline registers
   always_ff @(posedge clock) begin
      iw_ff       <= iw;
      ih_ff       <= ih;
      area_a_ff   <= AREA_BITS'(cand_ff.box_width) * AREA_BITS'(cand_ff.box_height);
      area_b_ff   <= AREA_BITS'(kept_rd_ff.box_width) * AREA_BITS'(kept_rd_ff.box_height);
      inter2_ff   <= AREA_BITS'(iw_ff) * AREA_BITS'(ih_ff);
      sum_ff      <= UNI_BITS'(area_a_ff) + UNI_BITS'(area_b_ff);
      uni_ff      <= sum_ff - UNI_BITS'(inter2_ff);
      inter3_ff   <= inter2_ff;
      prod_ff     <= PROD_BITS'(thr_ff) * PROD_BITS'(uni_ff);
      uni_zero_ff <= (uni_ff == '0);
      inter4_ff   <= inter3_ff;
   end

   // ratio test inter*256 > threshold*union
   assign hit = !uni_zero_ff &&
                (PROD_BITS'({inter4_ff, FRAC_BITS'(0)}) > prod_ff);

   assign slot_free = !rsp_valid_ff || rsp_tready;

   // sequencer
   always_comb begin
      state_in       = state_ff;
      cand_cnt_in    = cand_cnt_ff;
      pos_in         = pos_ff;
      walk_in        = walk_ff;
      kept_cnt_in    = kept_cnt_ff;
      k_in           = k_ff;
      emit_in        = emit_ff;
      drop_in        = drop_ff | (vld_ff[STAGES-1] & hit);
      vld_in         = {vld_ff[STAGES-2:0], (state_ff == S_CMP)};
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      cand_we        = 1'b0;
      cand_wa        = pos_ff;
      cand_wd        = nb_ff;
      cand_ra        = walk_ff[CAND_AW-1:0];
      kept_we        = 1'b0;
      kept_wa        = kept_cnt_ff[KEPT_AW-1:0];
      kept_ra        = emit_ff;
      rsp_load       = 1'b0;
      rsp_load_found = 1'b0;
      rsp_load_last  = 1'b0;
      req_tready     = (state_ff == S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            cand_ra = CAND_AW'(cand_cnt_ff - CAND_CW'(1));
            if (accept) begin
               state_in = S_SETUP;
               if (req_tuser && (cand_cnt_ff < CAND_CW'(gbn_pkg::MAX_CANDIDATES))) begin
                  cand_cnt_in = cand_cnt_ff + CAND_CW'(1);
                  if (cand_cnt_ff == '0) begin
                     cand_we = 1'b1;
                     cand_wa = '0;
                     cand_wd = req_box;
                  end else begin
                     pos_in   = cand_cnt_ff[CAND_AW-1:0];
                     state_in = S_INS_CMP;
                  end
               end
            end
         end
         // move lower-scored entries down one slot until the place is found
         S_INS_CMP: begin
            cand_ra = pos_ff - CAND_AW'(2);
            cand_we = 1'b1;
            if (cand_rd_ff.score < nb_ff.score) begin
               cand_wd = cand_rd_ff;
               pos_in  = pos_ff - CAND_AW'(1);
               if (pos_ff == CAND_AW'(1)) begin
                  state_in = S_INS_PUT;
               end
            end else begin
               state_in = S_SETUP;
            end
         end
         S_INS_PUT: begin
            cand_we  = 1'b1;
            state_in = S_SETUP;
         end
         S_SETUP: begin
            walk_in     = '0;
            kept_cnt_in = '0;
            emit_in     = '0;
            priority if (!end_ff) begin
               state_in = S_IDLE;
            end else if (cand_cnt_ff == '0) begin
               state_in = S_EMPTY;
            end else begin
               state_in = S_WALK_RD;
            end
         end
         S_WALK_RD: begin
            state_in = S_WALK_LD;
         end
         S_WALK_LD: begin
            drop_in  = 1'b0;
            k_in     = '0;
            state_in = (kept_cnt_ff == '0) ? S_KEEP : S_CMP;
         end
         // stream every kept box into the overlap pipeline
         S_CMP: begin
            kept_ra = k_ff;
            k_in    = k_ff + KEPT_AW'(1);
            if (k_ff == KEPT_AW'(kept_cnt_ff - KEPT_CW'(1))) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (vld_ff == '0) begin
               state_in = drop_ff ? S_NEXT : S_KEEP;
            end
         end
         S_KEEP: begin
            kept_we     = 1'b1;
            kept_cnt_in = kept_cnt_ff + KEPT_CW'(1);
            state_in    = S_NEXT;
         end
         S_NEXT: begin
            walk_in = walk_ff + CAND_CW'(1);
            if ((walk_ff + CAND_CW'(1) == cand_cnt_ff) || (kept_cnt_ff == limit)) begin
               cand_cnt_in = '0;
               state_in    = S_EMIT_RD;
            end else begin
               state_in = S_WALK_RD;
            end
         end
         S_EMIT_RD: begin
            state_in = S_EMIT_LD;
         end
         S_EMIT_LD: begin
            if (slot_free) begin
               rsp_load       = 1'b1;
               rsp_load_found = 1'b1;
               rsp_valid_in   = 1'b1;
               emit_in        = emit_ff + KEPT_AW'(1);
               if (KEPT_CW'(emit_ff) + KEPT_CW'(1) == kept_cnt_ff) begin
                  rsp_load_last = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  state_in = S_EMIT_RD;
               end
            end
         end
         S_EMPTY: begin
            if (slot_free) begin
               rsp_load      = 1'b1;
               rsp_load_last = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cand_cnt_ff  <= '0;
         pos_ff       <= '0;
         walk_ff      <= '0;
         kept_cnt_ff  <= '0;
         k_ff         <= '0;
         emit_ff      <= '0;
         drop_ff      <= 1'b0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cand_cnt_ff  <= cand_cnt_in;
         pos_ff       <= pos_in;
         walk_ff      <= walk_in;
         kept_cnt_ff  <= kept_cnt_in;
         k_ff         <= k_in;
         emit_ff      <= emit_in;
         drop_ff      <= drop_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // accepted item and candidate under test
   always_ff @(posedge clock) begin
      if (accept) begin
         nb_ff  <= req_box;
         end_ff <= req_tlast;
      end
      if (state_ff == S_WALK_LD) begin
         cand_ff <= cand_rd_ff;
      end
   end

   // candidate memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (cand_we) begin
         cand_mem[cand_wa] <= cand_wd;
      end
      cand_rd_ff <= cand_mem[cand_ra];
   end

   // kept-box memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (kept_we) begin
         kept_mem[kept_wa] <= cand_ff;
      end
      kept_rd_ff <= kept_mem[kept_ra];
   end

   // output register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_box_ff   <= rsp_load_found ? kept_rd_ff : '0;
         rsp_found_ff <= rsp_load_found;
         rsp_last_ff  <= rsp_load_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{gbn_pkg::PAD_BITS{1'b0}}, rsp_box_ff};
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

[sv/gbn_checker.sv]
// gbn_checker: port-level checks on the greedy box suppression unit,
// bound to greedy_box_nms_unit; depends on gbn_pkg
`timescale 1ns / 1ps
`default_nettype none

module gbn_checker (
   input wire                             clock,
   input wire                             reset,
   input wire                             req_tvalid,
   input wire                             req_tready,
   input wire                             rsp_tvalid,
   input wire                             rsp_tready,
   input wire [gbn_pkg::TDATA_BITS-1:0]   rsp_tdata,
   input wire                             rsp_tuser,
   input wire                             rsp_tlast
);

   // a stalled result holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // an accepted item always starts work, so input is busy the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input ready right after a transaction");

   // a not-found result is the only result of its set
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast)
      else $error("not-found result without last marker");

   // a not-found result carries no box
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("not-found result with box data");

endmodule

bind greedy_box_nms_unit gbn_checker u_gbn_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
